[hdl/arc_replacement_policy_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive replacement policy block.
// ---------------------------------------------------------------------------
`ifndef ARC_REPLACEMENT_POLICY_DEFINES_SVH
`define ARC_REPLACEMENT_POLICY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/arc_pkg.sv]
// ---------------------------------------------------------------------------
// arc_pkg
// Shared types and codes of the adaptive replacement policy block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

  // Width of target, capacity and resident count fields.
  localparam int PW = 7;
  localparam int KW = 32;

  localparam logic [PW-1:0] CAP_RESET = 7'd64;

  // List tags of a slot.
  localparam logic [2:0] L_EMPTY = 3'd0;
  localparam logic [2:0] L_T1    = 3'd1;
  localparam logic [2:0] L_T2    = 3'd2;
  localparam logic [2:0] L_B1    = 3'd3;
  localparam logic [2:0] L_B2    = 3'd4;
  localparam logic [2:0] L_WR    = 3'd5;
  localparam logic [2:0] L_WB1   = 3'd6;
  localparam logic [2:0] L_WB2   = 3'd7;

  // Operations. The spare code behaves as a lookup.
  localparam logic [1:0] F_LOOKUP = 2'd0;
  localparam logic [1:0] F_INSERT = 2'd1;
  localparam logic [1:0] F_TOUCH  = 2'd2;
  localparam logic [1:0] F_SPARE  = 2'd3;

  // Error codes.
  localparam logic [2:0] E_OK           = 3'd0;
  localparam logic [2:0] E_DUP          = 3'd1;
  localparam logic [2:0] E_TOUCH_ABSENT = 3'd2;
  localparam logic [2:0] E_TOUCH_GHOST  = 3'd3;
  localparam logic [2:0] E_FULL         = 3'd4;

  typedef struct packed {
    logic [1:0]    func;
    logic [KW-1:0] key;
    logic          data_ready;
  } req_t;

  typedef struct packed {
    logic [2:0]    found_where;
    logic [2:0]    error_code;
    logic          evicted_valid;
    logic [KW-1:0] evicted_key;
    logic [PW-1:0] target_p;
    logic [PW-1:0] resident_count;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/arc_req_if.sv]
// ---------------------------------------------------------------------------
// arc_req_if
// Request channel: valid/ready handshake carrying one request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface arc_req_if import arc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/arc_rsp_if.sv]
// ---------------------------------------------------------------------------
// arc_rsp_if
// Response channel: valid/ready handshake carrying one result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface arc_rsp_if import arc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/arc_div.sv]
// ---------------------------------------------------------------------------
// arc_div
// Iterative restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arc_div #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo
);

  localparam int CNTW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]    rem;
  logic [W-1:0]    dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [W:0]      trial;
  logic [W:0]      diff;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dvs};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNTW'(1);
      if (cnt == CNTW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
      quo <= {quo[W-2:0], ~diff[W]};
    end
  end

endmodule

`default_nettype wire

[hdl/arc_cell.sv]
// ---------------------------------------------------------------------------
// arc_cell
// One slot of the store; folds its entry into the passing scan record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arc_cell import arc_pkg::*; #(
  parameter int IW = 8,
  parameter int CW = 8,
  localparam int LRU_W  = 1 + IW + 2 * KW,
  localparam int SCAN_W = 1 + IW + 3 + 1 + IW + 7 * CW + 4 * LRU_W,
  localparam int WR_W   = 1 + IW + 3 + 1 + 1 + KW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IW-1:0]     id,
  input  wire logic [KW-1:0]     qkey,
  input  wire logic [KW-1:0]     now,
  input  wire logic [WR_W-1:0]   wr,
  input  wire logic [SCAN_W-1:0] scan_in,
  output logic      [SCAN_W-1:0] scan_out
);

  typedef struct packed {
    logic          v;
    logic [IW-1:0] idx;
    logic [KW-1:0] age;
    logic [KW-1:0] key;
  } lru_t;

  typedef struct packed {
    logic                 hit;
    logic [IW-1:0]        hidx;
    logic [2:0]           hlist;
    logic                 fv;
    logic [IW-1:0]        fidx;
    logic [6:0][CW-1:0]   cnt;
    lru_t [3:0]           lru;
  } scan_t;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic [2:0]    list;
    logic          stamp_en;
    logic          key_en;
    logic [KW-1:0] key;
  } wr_t;

  logic [KW-1:0] key_r;
  logic [KW-1:0] stamp_r;
  logic [2:0]    list_r;
  scan_t         si;
  scan_t         so;
  wr_t           w;
  logic [2:0]    li;
  logic [KW-1:0] age;
  logic          occ;
  logic          sel;

  assign si  = scan_in;
  assign w   = wr;
  assign sel = w.en && (w.idx == id);

  // Fold this slot into the scan record.
  always_comb begin
    so  = si;
    occ = (list_r != L_EMPTY);
    li  = list_r - 3'd1;
    age = now - stamp_r;
    if (occ && (key_r == qkey) && !si.hit) begin
      so.hit   = 1'b1;
      so.hidx  = id;
      so.hlist = list_r;
    end
    if (!occ && !si.fv) begin
      so.fv   = 1'b1;
      so.fidx = id;
    end
    if (occ) begin
      so.cnt[li] = si.cnt[li] + CW'(1);
    end
    if (list_r == L_T1 || list_r == L_T2 || list_r == L_B1 || list_r == L_B2) begin
      if (!si.lru[li[1:0]].v || (age > si.lru[li[1:0]].age)) begin
        so.lru[li[1:0]].v   = 1'b1;
        so.lru[li[1:0]].idx = id;
        so.lru[li[1:0]].age = age;
        so.lru[li[1:0]].key = key_r;
      end
    end
  end

  // List tag of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_r <= L_EMPTY;
    end else if (sel) begin
      list_r <= w.list;
    end
  end

  // Key, stamp and the registered hand-off to the next cell.
  always_ff @(posedge clk) begin
    if (sel && w.stamp_en) begin
      stamp_r <= now;
    end
    if (sel && w.key_en) begin
      key_r <= w.key;
    end
    scan_out <= so;
  end

endmodule

`default_nettype wire

[hdl/arc_replacement_policy.sv]
// Request time is set by the scan record walking the row of slot cells.
// One request is taken at a time; the next request is taken once the result
// is in the output register, and a stalled result holds the block until it is taken.
// Reset (synchronous, active high) empties every slot, clears p and the recency clock,
// and sets capacity to 64.
// ---------------------------------------------------------------------------
// arc_replacement_policy
// Adaptive replacement cache policy over 32-bit keys, built as a row of cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arc_replacement_policy_defines.svh"

module arc_replacement_policy import arc_pkg::*; #(
  parameter int MAX_CAPACITY  = 64,
  parameter int WAITING_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [PW-1:0] cfg_data,
  arc_req_if.sink            req,
  arc_rsp_if.source          rsp
);

  localparam int SLOTS  = 2 * MAX_CAPACITY + WAITING_DEPTH;
  localparam int IW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int MW     = ((CW > PW) ? CW : PW) + 2;
  localparam int LRU_W  = 1 + IW + 2 * KW;
  localparam int SCAN_W = 1 + IW + 3 + 1 + IW + 7 * CW + 4 * LRU_W;
  localparam int WR_W   = 1 + IW + 3 + 1 + 1 + KW;
  localparam int SCNW   = $clog2(SLOTS + 1);

  typedef struct packed {
    logic          v;
    logic [IW-1:0] idx;
    logic [KW-1:0] age;
    logic [KW-1:0] key;
  } lru_t;

  typedef struct packed {
    logic                 hit;
    logic [IW-1:0]        hidx;
    logic [2:0]           hlist;
    logic                 fv;
    logic [IW-1:0]        fidx;
    logic [6:0][CW-1:0]   cnt;
    lru_t [3:0]           lru;
  } scan_t;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic [2:0]    list;
    logic          stamp_en;
    logic          key_en;
    logic [KW-1:0] key;
  } wr_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_LATCH = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_PLAN  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t          state;
  logic [PW-1:0]   capacity;
  logic [PW-1:0]   p;
  logic [KW-1:0]   rclock;
  logic [1:0]      q_func;
  logic [KW-1:0]   q_key;
  logic            q_rdy;
  logic [SCNW-1:0] scan_cnt;
  logic [1:0]      wcnt;
  scan_t           res;
  scan_t           sl;
  wr_t             pw [3];
  wr_t             wr_bus;
  logic [2:0]      err_r;
  logic            ev_r;
  logic [KW-1:0]   evkey_r;
  logic [PW-1:0]   rc_r;
  logic [2:0]      where_r;
  logic            out_v;
  rsp_t            out_d;

  logic [SCAN_W-1:0] link [SLOTS+1];

  // ---- Row of slot cells ----
  assign link[0] = '0;
  assign sl      = link[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    arc_cell #(.IW(IW), .CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .id       (IW'(i)),
      .qkey     (q_key),
      .now      (rclock),
      .wr       (wr_bus),
      .scan_in  (link[i]),
      .scan_out (link[i+1])
    );
  end

  // ---- Ghost ratio divider, started from the scan result ----
  logic [2:0]    sl_where;
  logic [CW-1:0] sl_b1s;
  logic [CW-1:0] sl_b2s;
  logic          sl_b1_path;
  logic          div_done;
  logic [CW-1:0] div_quo;

  always_comb begin
    sl_where   = sl.hit ? sl.hlist : L_EMPTY;
    sl_b1s     = sl.cnt[L_B1 - 3'd1] + sl.cnt[L_WB1 - 3'd1];
    sl_b2s     = sl.cnt[L_B2 - 3'd1] + sl.cnt[L_WB2 - 3'd1];
    sl_b1_path = (sl_where == L_B1) || (sl_where == L_WB1);
  end

  arc_div #(.W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LATCH),
    .num   (sl_b1_path ? sl_b2s : sl_b1s),
    .den   (sl_b1_path ? sl_b1s : sl_b2s),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---- Plan of the step from the latched scan result ----
  logic [MW-1:0] cap_e;
  logic [MW-1:0] t1, t2, b1, b2, wr, wb1, wb2;
  logic [MW-1:0] b1s, b2s, l1, all_n, wait_tot, delta, psum;
  logic [2:0]    where;
  logic          c4;
  logic [IW-1:0] c4s;
  logic          upd;
  logic          rep;
  logic          b2o;
  logic [PW-1:0] pn;
  logic [2:0]    perr;
  logic          pev;
  logic [KW-1:0] pevkey;
  wr_t           w0, w1, w2;
  lru_t          lr;
  logic [2:0]    rep_to;
  logic [MW-1:0] prc;

  always_comb begin
    if (capacity == '0) begin
      cap_e = MW'(1);
    end else if (MW'(capacity) > MW'(MAX_CAPACITY)) begin
      cap_e = MW'(MAX_CAPACITY);
    end else begin
      cap_e = MW'(capacity);
    end
  end

  always_comb begin
    t1       = MW'(res.cnt[L_T1 - 3'd1]);
    t2       = MW'(res.cnt[L_T2 - 3'd1]);
    b1       = MW'(res.cnt[L_B1 - 3'd1]);
    b2       = MW'(res.cnt[L_B2 - 3'd1]);
    wr       = MW'(res.cnt[L_WR - 3'd1]);
    wb1      = MW'(res.cnt[L_WB1 - 3'd1]);
    wb2      = MW'(res.cnt[L_WB2 - 3'd1]);
    b1s      = b1 + wb1;
    b2s      = b2 + wb2;
    l1       = t1 + b1 + wb1;
    all_n    = l1 + t2 + b2 + wb2;
    wait_tot = wr + wb1 + wb2;
    where    = res.hit ? res.hlist : L_EMPTY;
    c4       = 1'b0;
    c4s      = res.fidx;
    upd      = 1'b0;
    rep      = 1'b0;
    b2o      = 1'b0;
    pn       = p;
    perr     = E_OK;
    pev      = 1'b0;
    pevkey   = '0;
    w0       = '0;
    w1       = '0;
    w2       = '0;
    lr       = '0;
    rep_to   = L_B1;
    delta    = MW'(1);
    psum     = '0;

    // Operation decode.
    case (q_func)
      F_INSERT: begin
        if (where == L_EMPTY) begin
          if (!res.fv) begin
            perr = E_FULL;
          end else if (q_rdy) begin
            c4 = 1'b1;
          end else if (wait_tot >= MW'(WAITING_DEPTH)) begin
            perr = E_FULL;
          end else begin
            w2 = '{en: 1'b1, idx: res.fidx, list: L_WR, stamp_en: 1'b1,
                   key_en: 1'b1, key: q_key};
          end
        end else if (where == L_B1 || where == L_B2) begin
          if (q_rdy) begin
            upd = 1'b1;
          end else if (wait_tot >= MW'(WAITING_DEPTH)) begin
            perr = E_FULL;
          end else begin
            w2 = '{en: 1'b1, idx: res.hidx, list: where + 3'd3, stamp_en: 1'b0,
                   key_en: 1'b0, key: q_key};
          end
        end else begin
          perr = E_DUP;
        end
      end
      F_TOUCH: begin
        if (where == L_EMPTY) begin
          perr = E_TOUCH_ABSENT;
        end else if (where == L_B1 || where == L_B2) begin
          perr = E_TOUCH_GHOST;
        end else if (q_rdy) begin
          upd = 1'b1;
        end
      end
      F_LOOKUP: begin
      end
      default: begin
      end
    endcase

    // Hit on a resident, ghost or waiting entry with data ready.
    if (upd) begin
      case (where)
        L_T1, L_T2: begin
          w2 = '{en: 1'b1, idx: res.hidx, list: L_T2, stamp_en: 1'b1,
                 key_en: 1'b0, key: q_key};
        end
        L_B1, L_WB1: begin
          if (b1s >= b2s || b1s == '0) delta = MW'(1);
          else delta = MW'(div_quo);
          psum = MW'(p) + delta;
          pn   = (psum > cap_e) ? cap_e[PW-1:0] : psum[PW-1:0];
          rep  = 1'b1;
          w2   = '{en: 1'b1, idx: res.hidx, list: L_T2, stamp_en: 1'b1,
                   key_en: 1'b0, key: q_key};
        end
        L_B2, L_WB2: begin
          if (b2s >= b1s || b2s == '0) delta = MW'(1);
          else delta = MW'(div_quo);
          psum = MW'(p) - delta;
          pn   = (MW'(p) > delta) ? psum[PW-1:0] : '0;
          rep  = 1'b1;
          b2o  = 1'b1;
          w2   = '{en: 1'b1, idx: res.hidx, list: L_T2, stamp_en: 1'b1,
                   key_en: 1'b0, key: q_key};
        end
        L_WR: begin
          c4  = 1'b1;
          c4s = res.hidx;
        end
        default: begin
        end
      endcase
    end

    // Miss path: make room and place the key at the head of T1.
    if (c4) begin
      if (l1 >= cap_e) begin
        if (t1 < cap_e && b1 != '0) begin
          w0  = '{en: res.lru[2].v, idx: res.lru[2].idx, list: L_EMPTY, stamp_en: 1'b0,
                  key_en: 1'b0, key: q_key};
          rep = 1'b1;
        end else if (res.lru[0].v) begin
          w1     = '{en: 1'b1, idx: res.lru[0].idx, list: L_EMPTY, stamp_en: 1'b0,
                     key_en: 1'b0, key: q_key};
          pev    = 1'b1;
          pevkey = res.lru[0].key;
        end
      end else if (all_n >= cap_e) begin
        if (all_n >= (cap_e << 1)) begin
          w0 = '{en: res.lru[3].v, idx: res.lru[3].idx, list: L_EMPTY, stamp_en: 1'b0,
                 key_en: 1'b0, key: q_key};
        end
        rep = 1'b1;
      end
      w2 = '{en: 1'b1, idx: c4s, list: L_T1, stamp_en: 1'b1, key_en: 1'b1, key: q_key};
    end

    // Demote the LRU entry of T1 or T2 into its ghost list.
    if (rep) begin
      if (t1 != '0 && (MW'(pn) < t1 || (b2o && t1 == MW'(pn)))) begin
        lr     = res.lru[0];
        rep_to = L_B1;
      end else begin
        lr     = res.lru[1];
        rep_to = L_B2;
      end
      if (lr.v) begin
        w1     = '{en: 1'b1, idx: lr.idx, list: rep_to, stamp_en: 1'b1,
                   key_en: 1'b0, key: q_key};
        pev    = 1'b1;
        pevkey = lr.key;
      end
    end

    // Resident count after the step.
    prc = t1 + t2 - MW'(pev);
    if (w2.en && (w2.list == L_T1 || w2.list == L_T2) && where != L_T1 && where != L_T2)
    begin
      prc = prc + MW'(1);
    end
  end

  // ---- Write bus towards the cells ----
  assign wr_bus = (state == S_WRITE) ? pw[wcnt] : '0;

  // ---- Control sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      wcnt     <= '0;
      p        <= '0;
      rclock   <= '0;
      out_v    <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCNW'(1);
          if (scan_cnt == SCNW'(SLOTS - 1)) begin
            state <= S_LATCH;
          end
        end
        S_LATCH: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          p     <= pn;
          wcnt  <= '0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (wr_bus.en && wr_bus.stamp_en) begin
            rclock <= rclock + KW'(1);
          end
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd2) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v || rsp.ready) begin
            out_v <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- Request, scan result, plan and result registers ----
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_func <= req.data.func;
      q_key  <= req.data.key;
      q_rdy  <= req.data.data_ready;
    end
    if (state == S_LATCH) begin
      res <= sl;
    end
    if (state == S_PLAN) begin
      pw[0]   <= w0;
      pw[1]   <= w1;
      pw[2]   <= w2;
      err_r   <= perr;
      ev_r    <= pev;
      evkey_r <= pevkey;
      rc_r    <= prc[PW-1:0];
      where_r <= where;
    end
    if (state == S_OUT && (!out_v || rsp.ready)) begin
      out_d.found_where    <= where_r;
      out_d.error_code     <= err_r;
      out_d.evicted_valid  <= ev_r;
      out_d.evicted_key    <= evkey_r;
      out_d.target_p       <= p;
      out_d.resident_count <= rc_r;
    end
  end

  // ---- Capacity register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  // ---- Assertions ----
  `ARC_ASSERT_NEXT(a_accept_starts_scan, clk, rst, req.valid && req.ready, state == S_SCAN, "accepted request did not start a scan")
  `ARC_ASSERT_NEXT(a_clock_only_in_write, clk, rst, state != S_WRITE, $stable(rclock), "recency clock moved outside the write phase")
  `ARC_ASSERT_NOW(a_error_no_write, clk, rst, state == S_WRITE && err_r != E_OK, !wr_bus.en, "slot write issued for a failed request")

endmodule

`default_nettype wire

[tb/arc_replacement_policy_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arc_replacement_policy_checker
// Watches the request, result and configuration ports of the replacement
// policy block. It keeps its own copy of the slot store and predicts one
// result for every request transfer. It then compares each result transfer
// with the oldest prediction, field by field.
// ---------------------------------------------------------------------------

module arc_replacement_policy_checker import arc_pkg::*; #(
  parameter int MAX_CAPACITY  = 64,
  parameter int WAITING_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [PW-1:0] cfg_data,
  arc_req_if            req,
  arc_rsp_if            rsp,
  output int            pending,
  output int            failures,
  output int            n_results,
  output int            n_evictions,
  output int            n_ghost_hits,
  output int            n_full
);

  localparam int SLOTS = 2 * MAX_CAPACITY + WAITING_DEPTH;

  // Shadow copy of the slot store and the policy state.
  logic [KW-1:0] slot_keys [SLOTS];
  logic [2:0]    slot_tags [SLOTS];
  logic [31:0]   slot_ages [SLOTS];
  logic [31:0]   use_clock;
  int            target;
  logic [PW-1:0] capacity_reg;
  logic          evict_flag;
  logic [KW-1:0] evict_key;

  rsp_t predicted_q[$];

  assign pending = predicted_q.size();

  function automatic int usable_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > MAX_CAPACITY) return MAX_CAPACITY;
    return int'(capacity_reg);
  endfunction

  function automatic int tag_count(logic [2:0] tag);
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_tags[i] == tag) n++;
    return n;
  endfunction

  function automatic int parked_total();
    return tag_count(L_WR) + tag_count(L_WB1) + tag_count(L_WB2);
  endfunction

  // Least recently used slot of a list; ties go to the lowest slot.
  function automatic int oldest_slot(logic [2:0] tag);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_tags[i] == tag) begin
        age = use_clock - slot_ages[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic void make_newest(int s, logic [2:0] tag);
    slot_tags[s] = tag;
    slot_ages[s] = use_clock;
    use_clock++;
  endfunction

  function automatic void demote_oldest(logic [2:0] from_tag, logic [2:0] to_tag);
    int v;
    v = oldest_slot(from_tag);
    if (v >= 0) begin
      evict_flag = 1'b1;
      evict_key = slot_keys[v];
      make_newest(v, to_tag);
    end
  endfunction

  // Pick T1 or T2 to give up a resident entry, steered by the target.
  function automatic void replace_resident(logic [2:0] origin);
    int t1;
    bit from_b2;
    t1 = tag_count(L_T1);
    from_b2 = (origin == L_B2 || origin == L_WB2);
    if (t1 > 0 && (target < t1 || (from_b2 && t1 == target))) demote_oldest(L_T1, L_B1);
    else demote_oldest(L_T2, L_B2);
  endfunction

  // Bring a brand new key into T1, making room first when the lists are full.
  function automatic void admit_new(int s, logic [KW-1:0] key, logic [2:0] origin);
    int cap, t1, b1, l1, total, v;
    cap = usable_capacity();
    t1 = tag_count(L_T1);
    b1 = tag_count(L_B1);
    l1 = t1 + b1 + tag_count(L_WB1);
    if (l1 >= cap) begin
      if (t1 < cap && b1 > 0) begin
        v = oldest_slot(L_B1);
        if (v >= 0) slot_tags[v] = L_EMPTY;
        replace_resident(origin);
      end else begin
        v = oldest_slot(L_T1);
        if (v >= 0) begin
          evict_flag = 1'b1;
          evict_key = slot_keys[v];
          slot_tags[v] = L_EMPTY;
        end
      end
    end else begin
      total = l1 + tag_count(L_T2) + tag_count(L_B2) + tag_count(L_WB2);
      if (total >= cap) begin
        if (total >= 2 * cap) begin
          v = oldest_slot(L_B2);
          if (v >= 0) slot_tags[v] = L_EMPTY;
        end
        replace_resident(origin);
      end
    end
    slot_keys[s] = key;
    make_newest(s, L_T1);
  endfunction

  // A hit with data available: promote, adapt on ghost hits, or admit a waiter.
  function automatic void promote(int s, logic [2:0] where);
    int b1, b2, step, cap;
    cap = usable_capacity();
    b1 = tag_count(L_B1) + tag_count(L_WB1);
    b2 = tag_count(L_B2) + tag_count(L_WB2);
    case (where)
      L_T1, L_T2: begin
        make_newest(s, L_T2);
      end
      L_B1, L_WB1: begin
        step = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
        target = (target + step > cap) ? cap : target + step;
        replace_resident(where);
        make_newest(s, L_T2);
        n_ghost_hits++;
      end
      L_B2, L_WB2: begin
        step = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
        target = (target > step) ? target - step : 0;
        replace_resident(where);
        make_newest(s, L_T2);
        n_ghost_hits++;
      end
      L_WR: begin
        admit_new(s, slot_keys[s], L_WR);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] settle(int s, logic [2:0] where, logic ready);
    if (ready) begin
      promote(s, where);
      return E_OK;
    end
    if (where == L_B1 || where == L_B2) begin
      if (parked_total() >= WAITING_DEPTH) return E_FULL;
      slot_tags[s] = (where == L_B1) ? L_WB1 : L_WB2;
    end
    return E_OK;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    int s, f;
    logic [2:0] where, err;
    rsp_t o;
    s = -1;
    f = -1;
    where = L_EMPTY;
    err = E_OK;
    evict_flag = 1'b0;
    evict_key = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_tags[i] != L_EMPTY) begin
        if (s < 0 && slot_keys[i] == r.key) s = i;
      end else if (f < 0) begin
        f = i;
      end
    end
    if (s >= 0) where = slot_tags[s];

    if (r.func == F_INSERT) begin
      if (where == L_EMPTY) begin
        if (f < 0) begin
          err = E_FULL;
        end else if (r.data_ready) begin
          admit_new(f, r.key, L_EMPTY);
        end else if (parked_total() >= WAITING_DEPTH) begin
          err = E_FULL;
        end else begin
          slot_keys[f] = r.key;
          make_newest(f, L_WR);
        end
      end else if (where == L_B1 || where == L_B2) begin
        err = settle(s, where, r.data_ready);
      end else begin
        err = E_DUP;
      end
    end else if (r.func == F_TOUCH) begin
      if (where == L_EMPTY) err = E_TOUCH_ABSENT;
      else if (where == L_B1 || where == L_B2) err = E_TOUCH_GHOST;
      else err = settle(s, where, r.data_ready);
    end

    o.found_where = where;
    o.error_code = err;
    o.evicted_valid = evict_flag;
    o.evicted_key = evict_flag ? evict_key : '0;
    o.target_p = target[PW-1:0];
    o.resident_count = PW'(tag_count(L_T1) + tag_count(L_T2));
    return o;
  endfunction

  function automatic void check_field(string name, logic [KW-1:0] exp_v, logic [KW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      failures++;
    end
  endfunction

  // Predict on request transfers, compare on result transfers.
  always @(posedge clk) begin
    rsp_t exp_r;
    rsp_t act_r;
    if (rst) begin
      foreach (slot_tags[i]) begin
        slot_tags[i] = L_EMPTY;
        slot_keys[i] = '0;
        slot_ages[i] = '0;
      end
      use_clock = '0;
      target = 0;
      capacity_reg = CAP_RESET;
      predicted_q.delete();
      failures = 0;
      n_results = 0;
      n_evictions = 0;
      n_ghost_hits = 0;
      n_full = 0;
    end else begin
      if (cfg_we) capacity_reg = cfg_data;
      if (req.valid && req.ready) begin
        exp_r = predict_result(req.data);
        if (exp_r.evicted_valid) n_evictions++;
        if (exp_r.error_code == E_FULL) n_full++;
        predicted_q = {predicted_q, exp_r};
      end
      if (rsp.valid && rsp.ready) begin
        act_r = rsp.data;
        n_results++;
        if (predicted_q.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, act_r);
          failures++;
        end else begin
          exp_r = predicted_q.pop_front();
          check_field("found_where", KW'(exp_r.found_where), KW'(act_r.found_where));
          check_field("error_code", KW'(exp_r.error_code), KW'(act_r.error_code));
          check_field("evicted_valid", KW'(exp_r.evicted_valid), KW'(act_r.evicted_valid));
          check_field("evicted_key", exp_r.evicted_key, act_r.evicted_key);
          check_field("target_p", KW'(exp_r.target_p), KW'(act_r.target_p));
          check_field("resident_count", KW'(exp_r.resident_count),
                      KW'(act_r.resident_count));
        end
      end
    end
  end

endmodule

[tb/arc_replacement_policy_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arc_replacement_policy_tb
// Drives lookup, insert and touch requests into the replacement policy block
// over several capacities and idling patterns. A directed opening covers the
// field extremes, every operation and the error cases; random traffic over
// small key pools then builds up ghost hits, adaptation and evictions.
// ---------------------------------------------------------------------------

module arc_replacement_policy_tb;
  import arc_pkg::*;

  localparam int RANDOM_PER_PHASE = 210;
  localparam int SETTLE_CYCLES    = 400;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [PW-1:0] cfg_data;
  int            send_idle_pct;
  int            stall_pct;
  int            pending;
  int            failures;
  int            n_results;
  int            n_evictions;
  int            n_ghost_hits;
  int            n_full;
  int            n_sent;
  logic [KW-1:0] key_pool [192];

  arc_req_if req ();
  arc_rsp_if rsp ();

  arc_replacement_policy dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  arc_replacement_policy_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .req          (req),
    .rsp          (rsp),
    .pending      (pending),
    .failures     (failures),
    .n_results    (n_results),
    .n_evictions  (n_evictions),
    .n_ghost_hits (n_ghost_hits),
    .n_full       (n_full)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side stalls at random according to the current phase.
  always @(posedge clk) begin
    rsp.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Send one request, with random idle cycles first, and wait for its transfer.
  task automatic send(logic [1:0] func, logic [KW-1:0] key, logic ready);
    req_t r;
    bit taken;
    r.func = func;
    r.key = key;
    r.data_ready = ready;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end
    n_sent++;
  endtask

  // Wait for every outstanding result, then for the block to go quiet.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [PW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic over a pool of keys about three times the capacity.
  task automatic random_phase(int cap_eff, int count);
    int span;
    int pick;
    logic [1:0] func;
    logic [KW-1:0] key;
    span = (3 * cap_eff + 4 > 191) ? 191 : 3 * cap_eff + 4;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25) func = F_LOOKUP;
      else if (pick < 65) func = F_INSERT;
      else if (pick < 95) func = F_TOUCH;
      else func = F_SPARE;
      if ($urandom_range(19) == 0) key = $urandom();
      else key = key_pool[$urandom_range(span)];
      send(func, key, $urandom_range(3) != 0);
    end
  endtask

  initial begin
    logic [PW-1:0] caps [8];
    int pats [4][2];
    caps = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd8, 7'd3, 7'd100};
    pats = '{'{0, 0}, '{50, 0}, '{0, 50}, '{21, 21}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    n_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of the key, every operation, duplicates and waiters.
    send(F_LOOKUP, 32'h0000_0000, 1'b0);
    send(F_LOOKUP, 32'hFFFF_FFFF, 1'b1);
    send(F_SPARE, 32'h5555_AAAA, 1'b1);
    send(F_TOUCH, 32'h0000_0005, 1'b1);
    send(F_INSERT, 32'h0000_0000, 1'b1);
    send(F_INSERT, 32'hFFFF_FFFF, 1'b1);
    send(F_INSERT, 32'h0000_0000, 1'b1);
    send(F_LOOKUP, 32'h0000_0000, 1'b0);
    send(F_TOUCH, 32'h0000_0000, 1'b1);
    send(F_TOUCH, 32'hFFFF_FFFF, 1'b0);
    send(F_INSERT, 32'h0000_0007, 1'b0);
    send(F_INSERT, 32'h0000_0007, 1'b1);
    send(F_TOUCH, 32'h0000_0007, 1'b0);
    send(F_TOUCH, 32'h0000_0007, 1'b1);

    // Small capacity: build ghosts, touch them, park them, overflow waiting.
    write_capacity(7'd2);
    for (int k = 1; k <= 4; k++) send(F_INSERT, 32'h1000_0000 + k, 1'b1);
    for (int k = 1; k <= 4; k++) send(F_TOUCH, 32'h1000_0000 + k, 1'b1);
    for (int k = 1; k <= 4; k++) send(F_INSERT, 32'h1000_0000 + k, 1'b0);
    for (int k = 0; k < 17; k++) send(F_INSERT, 32'h2000_0000 + k, 1'b0);
    for (int k = 1; k <= 4; k++) send(F_TOUCH, 32'h1000_0000 + k, 1'b1);
    for (int k = 0; k < 17; k++) send(F_TOUCH, 32'h2000_0000 + k, 1'b1);

    // Random phases over several capacities and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph]);
      send_idle_pct = pats[ph % 4][0];
      stall_pct = pats[ph % 4][1];
      random_phase((caps[ph] == 0) ? 1 : (caps[ph] > 64) ? 64 : caps[ph], RANDOM_PER_PHASE);
    end
    drain();

    $display("Covered %0d requests over eight capacities, %0d results checked.",
             n_sent, n_results);
    $display("Saw %0d evictions, %0d ghost hits and %0d store-full errors.",
             n_evictions, n_ghost_hits, n_full);
    if (failures == 0) begin
      $display("arc_replacement_policy test passed");
    end else begin
      $display("arc_replacement_policy test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("arc_replacement_policy test failed");
    $finish;
  end

endmodule
